>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int TIME_W     = 48;
	localparam int PERIOD_W   = 31;
	localparam int LOOK_W     = 16;
	localparam logic [LOOK_W-1:0] LOOK_RESET = 16'd200;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_FIRED    = 3'd0,
		KIND_ALLOC    = 3'd1,
		KIND_FULL     = 3'd2,
		KIND_CLEARED  = 3'd3,
		KIND_DEADLINE = 3'd4
	} kind_t;

	typedef struct packed {
		action_t             action;
		logic [TIME_W-1:0]   now_ms;
		logic [PERIOD_W-1:0] period_ms;
		logic [3:0]          slot_id;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [2:0]        slot;
		logic [TIME_W-1:0] deadline_ms;
		logic              last;
	} rsp_t;

	// command broadcast to every cell while a token walks the row
	typedef struct packed {
		action_t             op;
		logic [TIME_W-1:0]   now;
		logic [PERIOD_W-1:0] period;
	} cmd_t;

	// token handed from cell to cell; hit = slot taken (set) or minimum seen (tick)
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [TIME_W-1:0] best;
	} tok_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

endpackage

>>> rtl/pts_cell.sv
`timescale 1ns / 1ps

module pts_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  pts_pkg::cmd_t cmd,
	input  pts_pkg::tok_t tok_prev,
	input  logic          clr,
	output pts_pkg::tok_t tok_next,
	output logic          fire,
	output logic          take
);
	import pts_pkg::*;

	logic                in_use_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TIME_W-1:0]   due_q;
	logic [TIME_W-1:0]   nxt_a, nxt_b, resched, new_due;
	tok_t                tok_d;

	assign take = tok_prev.valid && (cmd.op == ACT_SET) && !tok_prev.hit && !in_use_q;
	assign fire = tok_prev.valid && (cmd.op == ACT_TICK) && in_use_q && (due_q <= cmd.now);

	always_comb begin
		nxt_a   = sat_add(due_q, TIME_W'(period_q));
		nxt_b   = sat_add(cmd.now, TIME_W'(period_q));
		// catch up to now when the slot has fallen a period or more behind
		resched = (nxt_a <= cmd.now) ? nxt_b : nxt_a;
		new_due = fire ? resched : due_q;
	end

	always_comb begin
		tok_d = tok_prev;
		if (cmd.op == ACT_SET) begin
			tok_d.hit = tok_prev.hit | take;
		end else if (cmd.op == ACT_TICK && in_use_q &&
		             (!tok_prev.hit || new_due < tok_prev.best)) begin
			tok_d.hit  = 1'b1;
			tok_d.best = new_due;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			tok_next <= '0;
		end else begin
			tok_next <= tok_d;
			if (clr)
				in_use_q <= 1'b0;
			else if (take)
				in_use_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			period_q <= cmd.period;
			due_q    <= sat_add(cmd.now, TIME_W'(cmd.period));
		end else if (fire) begin
			due_q    <= new_due;
		end
	end

endmodule

>>> rtl/periodic_timer_slot_table.sv
`timescale 1ns / 1ps

// Periodic timer slot table. A set or tick beat walks a token along a row of
// eight slot cells, one cell per clock, so busy rises once the beat is
// accepted, holding off the next beat until the token leaves the row; a clear,
// or an unused action, never raises busy and the next beat may follow at once.
// Results come out one per cycle on rsp with rsp_valid high for exactly that
// cycle and cannot be held off: fired slots appear as the token passes them, in
// slot order, and the deadline (or table full) result follows the token leaving
// the last cell. An allocated result appears as soon as the free cell is found.
// cfg_wr_en writes the idle lookahead; write it only while busy is low.
module periodic_timer_slot_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pts_pkg::req_t                 req,
	output logic                          rsp_valid,
	output pts_pkg::rsp_t                 rsp,
	input  logic                          cfg_wr_en,
	input  logic [pts_pkg::LOOK_W-1:0]    cfg_wr_data
);
	import pts_pkg::*;

	logic                  accept;
	logic                  launch;
	logic                  busy_q;
	logic [LOOK_W-1:0]     look_q;
	cmd_t                  cmd_q;
	tok_t                  tok_head_q;
	tok_t                  tok [SLOT_COUNT+1];
	logic [SLOT_COUNT-1:0] clr_vec, fire_vec, take_vec, tok_vld;
	logic [SLOT_IW-1:0]    evt_idx;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	rsp_t                  rsp_d;
	tok_t                  tail;

	assign accept = start && !busy_q;
	assign launch = accept && (req.action == ACT_SET || req.action == ACT_TICK);
	assign busy   = busy_q;
	assign tok[0] = tok_head_q;
	assign tail   = tok[SLOT_COUNT];

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			clr_vec[i] = accept && (req.action == ACT_CLEAR) && (req.slot_id == 4'(i));
			tok_vld[i] = tok[i].valid;
		end
	end

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		pts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd_q),
			.tok_prev (tok[g]),
			.clr      (clr_vec[g]),
			.tok_next (tok[g+1]),
			.fire     (fire_vec[g]),
			.take     (take_vec[g])
		);
	end

	always_comb begin
		evt_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (fire_vec[i] || take_vec[i])
				evt_idx = SLOT_IW'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q <= LOOK_RESET;
		end else if (cfg_wr_en) begin
			look_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			tok_head_q <= '0;
		end else begin
			tok_head_q <= {launch, 1'b0, TIME_W'(0)};
			if (launch) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= {req.action, req.now_ms,
			          (req.period_ms == '0) ? PERIOD_W'(1) : req.period_ms};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= (accept && req.action == ACT_CLEAR) || (|fire_vec) ||
			               (|take_vec) ||
			               (tail.valid && (cmd_q.op == ACT_TICK || !tail.hit));
		end
	end

	always_comb begin
		rsp_d = '0;
		if (accept && req.action == ACT_CLEAR) begin
			rsp_d.kind = KIND_CLEARED;
			rsp_d.last = 1'b1;
		end else if (|fire_vec) begin
			rsp_d.kind = KIND_FIRED;
			rsp_d.slot = 3'(evt_idx);
		end else if (|take_vec) begin
			rsp_d.kind = KIND_ALLOC;
			rsp_d.slot = 3'(evt_idx);
			rsp_d.last = 1'b1;
		end else if (tail.valid && cmd_q.op == ACT_TICK) begin
			rsp_d.kind        = KIND_DEADLINE;
			rsp_d.deadline_ms = tail.hit ? tail.best
			                             : sat_add(cmd_q.now, TIME_W'(look_q));
			rsp_d.last        = 1'b1;
		end else begin
			rsp_d.kind = KIND_FULL;
			rsp_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// only one token may be in the row at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tail.valid, tok_vld}))
		else $error("more than one token in the cell row");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({fire_vec, take_vec}))
		else $error("several cells reported in one cycle");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("token left the row while idle");

	a_tail_ends: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> !busy_q)
		else $error("busy held after the token left the row");

	a_deadline_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_DEADLINE || rsp.kind == KIND_FULL) |-> rsp.last)
		else $error("closing result without last");

endmodule

>>> test/timer_table_checker.sv
`timescale 1ns / 1ps

module timer_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  pts_pkg::req_t              req,
	input  logic                       rsp_valid,
	input  pts_pkg::rsp_t              rsp,
	input  logic                       cfg_wr_en,
	input  logic [pts_pkg::LOOK_W-1:0] cfg_wr_data,
	output int                         fail_count,
	output int                         waiting
);
	import pts_pkg::*;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	logic                slot_live   [SLOT_COUNT];
	logic [PERIOD_W-1:0] slot_every  [SLOT_COUNT];
	logic [TIME_W-1:0]   slot_due    [SLOT_COUNT];
	logic [LOOK_W-1:0]   lookahead_ms;
	rsp_t                due_results [$];
	int                  mismatches = 0;

	assign fail_count = mismatches;

	task automatic flag_mismatch(input string msg);
		$display("%0t ns  timer table: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [TIME_W-1:0] time_plus(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic void push_result(input kind_t k, input int idx,
		input logic [TIME_W-1:0] dl, input logic fin);
		rsp_t r;
		r.kind        = k;
		r.slot        = idx[2:0];
		r.deadline_ms = dl;
		r.last        = fin;
		due_results.push_back(r);
	endfunction

	// one accepted request against the shadow table
	function automatic void advance_timer_table(input req_t r);
		logic [PERIOD_W-1:0] per;
		logic [TIME_W-1:0]   nxt;
		logic [TIME_W-1:0]   best;
		logic                found;
		logic                placed;
		int                  i;
		case (r.action)
			ACT_SET: begin
				per    = (r.period_ms == '0) ? PERIOD_W'(1) : r.period_ms;
				placed = 1'b0;
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (!placed && !slot_live[i]) begin
						slot_live[i]  = 1'b1;
						slot_every[i] = per;
						slot_due[i]   = time_plus(r.now_ms, TIME_W'(per));
						push_result(KIND_ALLOC, i, '0, 1'b1);
						placed = 1'b1;
					end
				end
				if (!placed)
					push_result(KIND_FULL, 0, '0, 1'b1);
			end
			ACT_CLEAR: begin
				if (r.slot_id < SLOT_COUNT)
					slot_live[r.slot_id[2:0]] = 1'b0;
				push_result(KIND_CLEARED, 0, '0, 1'b1);
			end
			ACT_TICK: begin
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (slot_live[i] && slot_due[i] <= r.now_ms) begin
						push_result(KIND_FIRED, i, '0, 1'b0);
						nxt = time_plus(slot_due[i], TIME_W'(slot_every[i]));
						if (nxt <= r.now_ms)
							nxt = time_plus(r.now_ms, TIME_W'(slot_every[i]));
						slot_due[i] = nxt;
					end
				end
				found = 1'b0;
				best  = '0;
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (slot_live[i] && (!found || slot_due[i] < best)) begin
						best  = slot_due[i];
						found = 1'b1;
					end
				end
				if (!found)
					best = time_plus(r.now_ms, TIME_W'(lookahead_ms));
				push_result(KIND_DEADLINE, 0, best, 1'b1);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_live[i]  = 1'b0;
				slot_every[i] = '0;
				slot_due[i]   = '0;
			end
			lookahead_ms = LOOK_RESET;
			due_results.delete();
			waiting <= 0;
		end else begin
			if (rsp_valid) begin
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d slot %0d",
						rsp.kind, rsp.slot));
				end else begin
					want = due_results.pop_front();
					if (rsp.kind !== want.kind)
						flag_mismatch($sformatf("kind %0d, wanted %0d",
							rsp.kind, want.kind));
					if (rsp.slot !== want.slot)
						flag_mismatch($sformatf("slot %0d, wanted %0d (kind %0d)",
							rsp.slot, want.slot, want.kind));
					if (rsp.deadline_ms !== want.deadline_ms)
						flag_mismatch($sformatf("deadline %0h, wanted %0h (kind %0d)",
							rsp.deadline_ms, want.deadline_ms, want.kind));
					if (rsp.last !== want.last)
						flag_mismatch($sformatf("last %0b, wanted %0b (kind %0d)",
							rsp.last, want.last, want.kind));
				end
			end
			if (cfg_wr_en)
				lookahead_ms = cfg_wr_data;
			if (start && !busy)
				advance_timer_table(req);
			waiting <= due_results.size();
		end
	end

endmodule

>>> test/periodic_timer_slot_table_test.sv
`timescale 1ns / 1ps

module periodic_timer_slot_table_test;
	import pts_pkg::*;

	localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              busy;
	req_t              req         = '0;
	logic              rsp_valid;
	rsp_t              rsp;
	logic              cfg_wr_en   = 1'b0;
	logic [LOOK_W-1:0] cfg_wr_data = '0;
	int                fail_count;
	int                waiting;

	logic [TIME_W-1:0] wall_ms = '0;

	periodic_timer_slot_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	timer_table_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.waiting     (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("periodic_timer_slot_table_test: done, errors");
		$finish;
	end

	function automatic req_t mk(input action_t a, input logic [TIME_W-1:0] now,
		input logic [PERIOD_W-1:0] per, input logic [3:0] id);
		req_t r;
		r.action    = a;
		r.now_ms    = now;
		r.period_ms = per;
		r.slot_id   = id;
		return r;
	endfunction

	// offer one beat, hold it until taken, then idle the sender at random
	task automatic run_item(input req_t r, input int idle_pct);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// only once the table has drained and gone quiet
	task automatic write_lookahead(input logic [LOOK_W-1:0] v);
		start <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly a sane timeline; the rest is raw noise over the whole field range
	task automatic draw_item(output req_t r);
		logic [31:0] hi;
		logic [31:0] lo;
		int          pick;
		hi   = $urandom;
		lo   = $urandom;
		pick = $urandom_range(99);
		if (pick < 20) begin
			r = mk(action_t'($urandom_range(0, 3)), {hi[15:0], lo}, hi[31:1],
				lo[3:0] ^ hi[19:16]);
		end else begin
			wall_ms = wall_ms + TIME_W'($urandom_range(0, 40));
			if (pick < 45)
				r = mk(ACT_SET, wall_ms, PERIOD_W'($urandom_range(0, 60)), lo[3:0]);
			else if (pick < 63)
				r = mk(ACT_CLEAR, wall_ms, hi[30:0],
					(lo[7:4] == 4'd0) ? {1'b1, lo[2:0]} : {1'b0, lo[2:0]});
			else
				r = mk(ACT_TICK, wall_ms, hi[30:0], lo[3:0]);
		end
	endtask

	initial begin
		req_t        r;
		int          ph;
		int          pct;
		logic [15:0] look;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_lookahead(16'hFFFF);
		// empty table: lookahead saturating, then plain
		run_item(mk(ACT_TICK, TIME_MAX - 48'd100, '0, '0), 0);
		run_item(mk(ACT_TICK, '0, '0, '0), 0);
		// zero period raised to one; huge period near end of time saturates
		run_item(mk(ACT_SET, 48'd100, '0, '0), 0);
		run_item(mk(ACT_SET, TIME_MAX - 48'd10, PERIOD_MAX, 4'hF), 0);
		repeat (6) run_item(mk(ACT_SET, 48'd100, 31'd5, '0), 0);
		run_item(mk(ACT_SET, 48'd100, 31'd9, '0), 0);
		run_item(mk(ACT_TICK, 48'd101, '0, '0), 0);
		// late tick: reschedule relative to now
		run_item(mk(ACT_TICK, 48'd300, '0, '0), 0);
		run_item(mk(ACT_CLEAR, '0, '0, 4'd15), 0);
		run_item(mk(ACT_CLEAR, '0, '0, 4'd8), 0);
		run_item(mk(ACT_CLEAR, '0, '0, 4'd3), 0);
		run_item(mk(ACT_CLEAR, '0, '0, 4'd3), 0);
		run_item(mk(ACT_NONE, 48'h5A5A_A5A5_1234, 31'h2AAA_5555, 4'hA), 0);
		run_item(mk(ACT_SET, 48'd500, 31'd7, '0), 0);
		run_item(mk(ACT_TICK, TIME_MAX, '0, '0), 0);
		run_item(mk(ACT_TICK, '0, '0, '0), 0);
		run_item(mk(ACT_CLEAR, '0, '0, 4'd1), 0);

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin look = 16'd1; pct = 0; end
				1: begin look = 16'd0; pct = 79; end
				2: begin look = 16'($urandom_range(1, 65535)); pct = 22; end
				default: begin look = LOOK_RESET; pct = 0; end
			endcase
			write_lookahead(look);
			repeat (80) begin
				draw_item(r);
				run_item(r, pct);
			end
		end

		start <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("periodic_timer_slot_table_test: done, clean");
		else
			$display("periodic_timer_slot_table_test: done, errors");
		$finish;
	end

endmodule

>>> files.f
rtl/pts_pkg.sv
rtl/pts_cell.sv
rtl/periodic_timer_slot_table.sv
test/timer_table_checker.sv
test/periodic_timer_slot_table_test.sv
